FILE: rtl/mroi_pkg.sv
`default_nettype none

package mroi_pkg;

    localparam int MAX_DIMS_DEF    = 4;
    localparam int MAX_EXTENT_DEF  = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int FIELD_W    = 32;
    localparam int OFF_W      = 32;
    localparam int DSEL_W     = 2;
    localparam int POS_W      = 4;
    localparam int NUMD_W     = 3;
    localparam int EXT_W      = 5;
    localparam int EXT_MAX    = 2 ** EXT_W - 1;
    localparam int NUM_EXT    = 4;
    localparam int NUM_IDX    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam int DIV_BITS   = 4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MAJOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT0     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT2     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT3     = 3'd5;

endpackage

`default_nettype wire

FILE: rtl/mroi_in_if.sv
`default_nettype none

interface mroi_in_if;

    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [mroi_pkg::DSEL_W-1:0]   dim_select;
    logic [mroi_pkg::POS_W-1:0]    position;
    logic [mroi_pkg::FIELD_W-1:0]  entry_value;
    logic [mroi_pkg::OFF_W-1:0]    offset;

    modport source (
        output valid,
        output opcode,
        output dim_select,
        output position,
        output entry_value,
        output offset,
        input  ready
    );

    modport sink (
        input  valid,
        input  opcode,
        input  dim_select,
        input  position,
        input  entry_value,
        input  offset,
        output ready
    );

endinterface

`default_nettype wire

FILE: rtl/mroi_out_if.sv
`default_nettype none

interface mroi_out_if;

    logic                          valid;
    logic                          ready;
    logic [mroi_pkg::FIELD_W-1:0]  index0;
    logic [mroi_pkg::FIELD_W-1:0]  index1;
    logic [mroi_pkg::FIELD_W-1:0]  index2;
    logic [mroi_pkg::FIELD_W-1:0]  index3;
    logic                          past_end;

    modport source (
        output valid,
        output index0,
        output index1,
        output index2,
        output index3,
        output past_end,
        input  ready
    );

    modport sink (
        input  valid,
        input  index0,
        input  index1,
        input  index2,
        input  index3,
        input  past_end,
        output ready
    );

endinterface

`default_nettype wire

FILE: rtl/mixed_radix_offset_to_index.sv
// A load transaction writes one table entry; the block stays ready.
// A query divides the offset by each extent, checks the final quotient, then reads one
// entry per dimension unless out of range; the next query is taken once the result is registered.
// The shared division step retires four offset bits per cycle,
// and each table read goes through S_READ and S_CAPTURE at the single registered read port.
// Reset clears control state and the registers to their defaults; table entries stay undefined.
`default_nettype none

module mixed_radix_offset_to_index #(
    parameter int MAX_DIMS    = mroi_pkg::MAX_DIMS_DEF,
    parameter int MAX_EXTENT  = mroi_pkg::MAX_EXTENT_DEF,
    parameter int VALUE_WIDTH = mroi_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [mroi_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  wire logic [mroi_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    mroi_in_if.sink                                in_ch,
    mroi_out_if.source                             out_ch
);

    import mroi_pkg::*;

    localparam int EXT_CAP = (MAX_EXTENT < EXT_MAX) ? MAX_EXTENT : EXT_MAX;
    localparam int NDIM_W  = $clog2(MAX_DIMS + 1);

    logic [NDIM_W-1:0]                num_dims_reg, num_dims_next;
    logic                             right_major_reg, right_major_next;
    logic [EXT_W-1:0]                 ext_reg [NUM_EXT];
    logic [EXT_W-1:0]                 ext_next [NUM_EXT];
    logic [NDIM_W-1:0]                ndim_wr;
    logic [EXT_W-1:0]                 ext_wr;
    logic [MAX_DIMS-1:0][EXT_W-1:0]   ext_by_dim;

    // Out-of-range settings are folded into the legal range when written.
    always_comb
    begin
        int nd;
        int ex;
        nd = int'(cfg_wr_data[NUMD_W-1:0]);
        ex = int'(cfg_wr_data[EXT_W-1:0]);
        if (nd == 0)
        begin
            nd = 1;
        end
        else if (nd > MAX_DIMS)
        begin
            nd = MAX_DIMS;
        end
        if (ex == 0)
        begin
            ex = 1;
        end
        else if (ex > EXT_CAP)
        begin
            ex = EXT_CAP;
        end
        ndim_wr = NDIM_W'(nd);
        ext_wr  = EXT_W'(ex);
    end

    always_comb
    begin
        num_dims_next    = num_dims_reg;
        right_major_next = right_major_reg;
        ext_next         = ext_reg;
        if (cfg_wr_en)
        begin
            case (cfg_wr_index)
                REG_NUM_DIMS:    num_dims_next    = ndim_wr;
                REG_RIGHT_MAJOR: right_major_next = cfg_wr_data[0];
                REG_EXTENT0:     ext_next[0]      = ext_wr;
                REG_EXTENT1:     ext_next[1]      = ext_wr;
                REG_EXTENT2:     ext_next[2]      = ext_wr;
                REG_EXTENT3:     ext_next[3]      = ext_wr;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg    <= NDIM_W'(1);
            right_major_reg <= 1'b0;
            for (int i = 0; i < NUM_EXT; i++)
            begin
                ext_reg[i] <= EXT_W'(1);
            end
        end
        else
        begin
            num_dims_reg    <= num_dims_next;
            right_major_reg <= right_major_next;
            ext_reg         <= ext_next;
        end
    end

    // Dimensions without an extent register have an extent of one.
    for (genvar g = 0; g < MAX_DIMS; g++)
    begin : g_ext
        if (g < NUM_EXT)
        begin : g_reg
            assign ext_by_dim[g] = ext_reg[g];
        end
        else
        begin : g_one
            assign ext_by_dim[g] = EXT_W'(1);
        end
    end

    mroi_seq #(
        .MAX_DIMS    (MAX_DIMS),
        .MAX_EXTENT  (MAX_EXTENT),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .num_dims    (num_dims_reg),
        .right_major (right_major_reg),
        .extent      (ext_by_dim),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    a_num_dims_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (num_dims_reg != '0) && (int'(num_dims_reg) <= MAX_DIMS))
        else $error("num_dims register outside its legal range");

    a_extent_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (ext_reg[0] != '0) && (ext_reg[1] != '0) && (ext_reg[2] != '0) && (ext_reg[3] != '0))
        else $error("extent register holds zero");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && (in_ch.opcode == OP_QUERY)) |=> !in_ch.ready)
        else $error("query transaction did not occupy the sequencer");

    a_load_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && (in_ch.opcode == OP_LOAD)) |=> in_ch.ready)
        else $error("load transaction stalled the input");

    a_result_ends_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> in_ch.ready)
        else $error("result appeared while a query was still in progress");

endmodule

`default_nettype wire

FILE: rtl/mroi_ram.sv
`default_nettype none

module mroi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/mroi_div_step.sv
`default_nettype none

module mroi_div_step #(
    parameter int STEPS = mroi_pkg::DIV_BITS
) (
    input  wire logic [mroi_pkg::EXT_W-1:0] rem_in,
    input  wire logic [STEPS-1:0]           bits_in,
    input  wire logic [mroi_pkg::EXT_W-1:0] divisor,
    output logic      [mroi_pkg::EXT_W-1:0] rem_out,
    output logic      [STEPS-1:0]           quo_out
);

    import mroi_pkg::*;

    // Restoring division, one dividend bit per step. The remainder stays
    // below the divisor, so each trial value fits in one extra bit.
    always_comb
    begin
        logic [EXT_W-1:0] r;
        logic [EXT_W:0]   trial;
        r = rem_in;
        trial = '0;
        quo_out = '0;
        for (int i = STEPS - 1; i >= 0; i--)
        begin
            trial = {r, bits_in[i]};
            if (trial >= {1'b0, divisor})
            begin
                trial = trial - {1'b0, divisor};
                quo_out[i] = 1'b1;
            end
            else
            begin
                quo_out[i] = 1'b0;
            end
            r = trial[EXT_W-1:0];
        end
        rem_out = r;
    end

endmodule

`default_nettype wire

FILE: rtl/mroi_seq.sv
`default_nettype none

module mroi_seq #(
    parameter int MAX_DIMS    = mroi_pkg::MAX_DIMS_DEF,
    parameter int MAX_EXTENT  = mroi_pkg::MAX_EXTENT_DEF,
    parameter int VALUE_WIDTH = mroi_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic [$clog2(MAX_DIMS+1)-1:0]             num_dims,
    input  wire logic                                      right_major,
    input  wire logic [MAX_DIMS-1:0][mroi_pkg::EXT_W-1:0]  extent,
    mroi_in_if.sink                                        in_ch,
    mroi_out_if.source                                     out_ch
);

    import mroi_pkg::*;

    localparam int EXT_CAP = (MAX_EXTENT < EXT_MAX) ? MAX_EXTENT : EXT_MAX;
    localparam int DIG_W   = $clog2(EXT_CAP);
    localparam int K_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DEPTH   = MAX_DIMS * MAX_EXTENT;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int STEPS   = OFF_W / DIV_BITS;
    localparam int CNT_W   = (STEPS > 1) ? $clog2(STEPS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_READ,
        S_CAPTURE,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [OFF_W-1:0]        work_reg, work_next;
    logic [EXT_W-1:0]        rem_reg, rem_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [K_W-1:0]          k_reg, k_next;
    logic [DIG_W-1:0]        digit_reg [MAX_DIMS];
    logic [DIG_W-1:0]        digit_next [MAX_DIMS];
    logic [FIELD_W-1:0]      idx_reg [NUM_IDX];
    logic [FIELD_W-1:0]      idx_next [NUM_IDX];
    logic                    oor_reg, oor_next;
    logic                    out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0]      out_idx_reg [NUM_IDX];
    logic [FIELD_W-1:0]      out_idx_next [NUM_IDX];
    logic                    out_oor_reg, out_oor_next;

    logic                    in_acc;
    logic                    out_acc;
    logic                    last_k;
    logic [K_W-1:0]          dim_cur;
    logic [EXT_W-1:0]        ext_cur;
    logic [EXT_W-1:0]        rem_new;
    logic [DIV_BITS-1:0]     quo_bits;
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [VALUE_WIDTH-1:0]  ram_rdata;

    assign in_acc  = in_ch.valid && in_ch.ready;
    assign out_acc = out_ch.valid && out_ch.ready;
    assign last_k  = (int'(k_reg) == int'(num_dims) - 1);
    assign dim_cur = right_major ? K_W'(int'(num_dims) - 1 - int'(k_reg)) : k_reg;
    assign ext_cur = extent[dim_cur];

    mroi_div_step #(
        .STEPS (DIV_BITS)
    ) u_div_step (
        .rem_in  (rem_reg),
        .bits_in (work_reg[OFF_W-1 -: DIV_BITS]),
        .divisor (ext_cur),
        .rem_out (rem_new),
        .quo_out (quo_bits)
    );

    assign ram_we = in_acc && (in_ch.opcode == OP_LOAD)
                    && (int'(in_ch.dim_select) < MAX_DIMS)
                    && (int'(in_ch.position) < MAX_EXTENT);
    assign ram_waddr = ADDR_W'(int'(in_ch.dim_select) * MAX_EXTENT + int'(in_ch.position));
    assign ram_raddr = ADDR_W'(int'(dim_cur) * MAX_EXTENT + int'(digit_reg[k_reg]));

    mroi_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (VALUE_WIDTH'(in_ch.entry_value)),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        digit_next     = digit_reg;
        idx_next       = idx_reg;
        oor_next       = oor_reg;
        out_idx_next   = out_idx_reg;
        out_oor_next   = out_oor_reg;
        out_valid_next = out_valid_reg && !out_acc;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (in_ch.opcode == OP_QUERY))
                begin
                    work_next  = in_ch.offset;
                    rem_next   = '0;
                    cnt_next   = '0;
                    k_next     = '0;
                    oor_next   = 1'b0;
                    for (int i = 0; i < NUM_IDX; i++)
                    begin
                        idx_next[i] = '0;
                    end
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                work_next = {work_reg[OFF_W-DIV_BITS-1:0], quo_bits};
                rem_next  = rem_new;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    digit_next[k_reg] = rem_new[DIG_W-1:0];
                    rem_next = '0;
                    cnt_next = '0;
                    if (last_k)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        k_next = k_reg + K_W'(1);
                    end
                end
            end
            S_CHECK:
            begin
                // A nonzero final quotient means the offset reaches past the
                // product of the extents.
                if (work_reg != '0)
                begin
                    oor_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CAPTURE;
            end
            S_CAPTURE:
            begin
                for (int i = 0; i < NUM_IDX; i++)
                begin
                    if (int'(dim_cur) == i)
                    begin
                        idx_next[i] = FIELD_W'(ram_rdata);
                    end
                end
                if (last_k)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = k_reg + K_W'(1);
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_idx_next   = idx_reg;
                    out_oor_next   = oor_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            work_reg      <= '0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            oor_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_oor_reg   <= 1'b0;
            for (int i = 0; i < MAX_DIMS; i++)
            begin
                digit_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_IDX; i++)
            begin
                idx_reg[i]     <= '0;
                out_idx_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            work_reg      <= work_next;
            rem_reg       <= rem_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            oor_reg       <= oor_next;
            out_valid_reg <= out_valid_next;
            out_oor_reg   <= out_oor_next;
            digit_reg     <= digit_next;
            idx_reg       <= idx_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    assign in_ch.ready     = (state_reg == S_IDLE);
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.index0   = out_idx_reg[0];
    assign out_ch.index1   = out_idx_reg[1];
    assign out_ch.index2   = out_idx_reg[2];
    assign out_ch.index3   = out_idx_reg[3];
    assign out_ch.past_end = out_oor_reg;

endmodule

`default_nettype wire

FILE: bench/tb_mixed_radix_offset_to_index.sv
`timescale 1ns / 100ps

module tb_mixed_radix_offset_to_index;

    import mroi_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int IDLE_PCT       = 21;
    localparam int SETTLE_CYCLES  = 50;
    localparam int PHASES         = 16;
    localparam int PHASE_ITEMS    = 48;
    localparam int CALM_PHASE     = 5;
    localparam int DIRECTED_ROWS  = 41;
    localparam int PRINT_LIMIT    = 60;
    localparam int TABLE_DEPTH    = MAX_DIMS_DEF * MAX_EXTENT_DEF;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

    typedef struct packed {
        logic [NUM_IDX-1:0][FIELD_W-1:0] index;
        logic                            past_end;
    } tuple_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_LOAD,
        ROW_QUERY
    } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   reg_index;
        logic [CFG_DATA_W-1:0]  reg_data;
        logic [DSEL_W-1:0]      dsel;
        logic [POS_W-1:0]       pos;
        logic [FIELD_W-1:0]     value;
        logic [OFF_W-1:0]       off;
        bit                     typed;
        tuple_t                 expected;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_wr_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;

    mroi_in_if  in_ch ();
    mroi_out_if out_ch ();

    mixed_radix_offset_to_index i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_ch        (in_ch),
        .out_ch       (out_ch)
    );

    logic [FIELD_W-1:0]     index_store [TABLE_DEPTH];
    logic [NUMD_W-1:0]      cfg_dims;
    logic                   cfg_rmajor;
    logic [EXT_W-1:0]       cfg_extent [NUM_EXT];

    tuple_t                 pending_tuples [$];
    bit                     calm;
    int                     mismatch_count;
    int                     loads_sent;
    int                     queries_sent;
    int                     tuples_checked;
    int                     oor_checked;
    int                     config_writes;

    always #(HALF_PERIOD) clk = ~clk;

    function automatic int active_dims();
        if (cfg_dims == 0)
        begin
            return 1;
        end
        if (cfg_dims > MAX_DIMS_DEF)
        begin
            return MAX_DIMS_DEF;
        end
        return int'(cfg_dims);
    endfunction

    function automatic int dim_extent(int d);
        if (cfg_extent[d] == 0)
        begin
            return 1;
        end
        if (cfg_extent[d] > MAX_EXTENT_DEF)
        begin
            return MAX_EXTENT_DEF;
        end
        return int'(cfg_extent[d]);
    endfunction

    function automatic int span_length();
        int p;
        p = 1;
        for (int d = 0; d < active_dims(); d++)
        begin
            p = p * dim_extent(d);
        end
        return p;
    endfunction

    function automatic tuple_t decompose_offset(logic [OFF_W-1:0] off);
        tuple_t r;
        longint rest;
        longint digit;
        int n;
        int d;
        int e;
        r = '0;
        if (longint'(off) >= longint'(span_length()))
        begin
            r.past_end = 1'b1;
            return r;
        end
        n = active_dims();
        rest = longint'(off);
        for (int k = 0; k < n; k++)
        begin
            d = cfg_rmajor ? (n - 1 - k) : k;
            e = dim_extent(d);
            digit = rest % e;
            r.index[d] = index_store[d * MAX_EXTENT_DEF + int'(digit)];
            rest = rest / e;
        end
        return r;
    endfunction

    function automatic stim_row_t make_row(row_kind_t kind);
        stim_row_t r;
        r.kind      = kind;
        r.reg_index = '0;
        r.reg_data  = '0;
        r.dsel      = '0;
        r.pos       = '0;
        r.value     = '0;
        r.off       = '0;
        r.typed     = 1'b0;
        r.expected  = '0;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        stim_row_t r;
        r = make_row(ROW_CFG);
        r.reg_index = idx;
        r.reg_data  = data;
        return r;
    endfunction

    function automatic stim_row_t load_row(logic [DSEL_W-1:0] dsel, logic [POS_W-1:0] pos,
                                           logic [FIELD_W-1:0] value);
        stim_row_t r;
        r = make_row(ROW_LOAD);
        r.dsel  = dsel;
        r.pos   = pos;
        r.value = value;
        return r;
    endfunction

    function automatic stim_row_t query_row(logic [OFF_W-1:0] off);
        stim_row_t r;
        r = make_row(ROW_QUERY);
        r.off = off;
        return r;
    endfunction

    function automatic stim_row_t checked_row(logic [OFF_W-1:0] off, logic [FIELD_W-1:0] first,
                                              logic oor);
        stim_row_t r;
        r = query_row(off);
        r.typed             = 1'b1;
        r.expected.index[0] = first;
        r.expected.past_end = oor;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
        begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    task automatic send_item(input logic op, input logic [DSEL_W-1:0] dsel,
                             input logic [POS_W-1:0] pos, input logic [FIELD_W-1:0] value,
                             input logic [OFF_W-1:0] off, input bit typed,
                             input tuple_t typed_exp);
        tuple_t exp_tuple;
        @(negedge clk);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.opcode      = op;
        in_ch.dim_select  = dsel;
        in_ch.position    = pos;
        in_ch.entry_value = value;
        in_ch.offset      = off;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        if (op == OP_LOAD)
        begin
            index_store[{dsel, pos}] = value;
            loads_sent++;
        end
        else
        begin
            exp_tuple = typed ? typed_exp : decompose_offset(off);
            pending_tuples.insert(pending_tuples.size(), exp_tuple);
            queries_sent++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_tuples.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en    = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data  = data;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_NUM_DIMS:    cfg_dims      = data[NUMD_W-1:0];
            REG_RIGHT_MAJOR: cfg_rmajor    = data[0];
            REG_EXTENT0:     cfg_extent[0] = data;
            REG_EXTENT1:     cfg_extent[1] = data;
            REG_EXTENT2:     cfg_extent[2] = data;
            REG_EXTENT3:     cfg_extent[3] = data;
            default:         ;
        endcase
        config_writes++;
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] dims, input logic rmajor,
                                 input logic [CFG_DATA_W-1:0] e0, input logic [CFG_DATA_W-1:0] e1,
                                 input logic [CFG_DATA_W-1:0] e2, input logic [CFG_DATA_W-1:0] e3);
        write_reg(REG_NUM_DIMS, dims);
        write_reg(REG_RIGHT_MAJOR, {4'b0, rmajor});
        write_reg(REG_EXTENT0, e0);
        write_reg(REG_EXTENT1, e1);
        write_reg(REG_EXTENT2, e2);
        write_reg(REG_EXTENT3, e3);
        if ($urandom_range(3) == 0)
        begin
            write_reg($urandom_range(1) ? REG_SPARE6 : REG_SPARE7, CFG_DATA_W'($urandom()));
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_extent();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
        begin
            return '0;
        end
        if (pick == 1)
        begin
            return CFG_DATA_W'($urandom_range(EXT_MAX, MAX_EXTENT_DEF + 1));
        end
        return CFG_DATA_W'($urandom_range(MAX_EXTENT_DEF, 1));
    endfunction

    task automatic random_item();
        logic [FIELD_W-1:0] value;
        logic [OFF_W-1:0]   off;
        int                 span;
        int                 pick;
        span  = span_length();
        value = $urandom();
        off   = $urandom();
        pick  = $urandom_range(99);
        if (pick < 25)
        begin
            if (pick < 3)
            begin
                value = '0;
            end
            else if (pick < 6)
            begin
                value = '1;
            end
            send_item(OP_LOAD, DSEL_W'($urandom()), POS_W'($urandom()), value, off, 1'b0, '0);
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                off = OFF_W'($urandom_range(span - 1));
            end
            else if (pick < 78)
            begin
                off = OFF_W'(span - 1);
            end
            else if (pick < 84)
            begin
                off = '0;
            end
            else if (pick < 92)
            begin
                off = OFF_W'(span + $urandom_range(15));
            end
            send_item(OP_QUERY, DSEL_W'($urandom()), POS_W'($urandom()), value, off, 1'b0, '0);
        end
    endtask

    always @(negedge clk)
    begin
        out_ch.ready = calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin : result_check
        tuple_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_tuples.size() == 0)
            begin
                report_mismatch("result arrived with no query outstanding");
            end
            else
            begin
                want = pending_tuples.pop_front();
                if (out_ch.index0 !== want.index[0])
                begin
                    report_mismatch($sformatf("index0 got %h want %h",
                                              out_ch.index0, want.index[0]));
                end
                if (out_ch.index1 !== want.index[1])
                begin
                    report_mismatch($sformatf("index1 got %h want %h",
                                              out_ch.index1, want.index[1]));
                end
                if (out_ch.index2 !== want.index[2])
                begin
                    report_mismatch($sformatf("index2 got %h want %h",
                                              out_ch.index2, want.index[2]));
                end
                if (out_ch.index3 !== want.index[3])
                begin
                    report_mismatch($sformatf("index3 got %h want %h",
                                              out_ch.index3, want.index[3]));
                end
                if (out_ch.past_end !== want.past_end)
                begin
                    report_mismatch($sformatf("past_end got %b want %b",
                                              out_ch.past_end, want.past_end));
                end
                tuples_checked++;
                if (want.past_end)
                begin
                    oor_checked++;
                end
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("Timeout: the block stopped making progress.");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        stim_row_t              directed_rows [DIRECTED_ROWS];
        stim_row_t              row;
        logic [CFG_DATA_W-1:0]  dims;
        logic                   rmajor;
        logic [CFG_DATA_W-1:0]  ext [NUM_EXT];

        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_index      = '0;
        cfg_wr_data       = '0;
        in_ch.valid       = 1'b0;
        in_ch.opcode      = OP_LOAD;
        in_ch.dim_select  = '0;
        in_ch.position    = '0;
        in_ch.entry_value = '0;
        in_ch.offset      = '0;
        calm              = 1'b0;
        mismatch_count    = 0;
        loads_sent        = 0;
        queries_sent      = 0;
        tuples_checked    = 0;
        oor_checked       = 0;
        config_writes     = 0;
        cfg_dims          = NUMD_W'(1);
        cfg_rmajor        = 1'b0;
        for (int d = 0; d < NUM_EXT; d++)
        begin
            cfg_extent[d] = EXT_W'(1);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Every table entry is written once before any query can select it.
        for (int d = 0; d < MAX_DIMS_DEF; d++)
        begin
            for (int p = 0; p < MAX_EXTENT_DEF; p++)
            begin
                send_item(OP_LOAD, DSEL_W'(d), POS_W'(p), $urandom(), $urandom(), 1'b0, '0);
            end
        end

        directed_rows = '{
            checked_row(32'd1, 32'h0, 1'b1),
            checked_row(32'hFFFF_FFFF, 32'h0, 1'b1),
            load_row(2'd0, 4'd0, 32'hFFFF_FFFF),
            checked_row(32'd0, 32'hFFFF_FFFF, 1'b0),
            load_row(2'd0, 4'd0, 32'h0),
            checked_row(32'd0, 32'h0, 1'b0),
            cfg_row(REG_NUM_DIMS, 5'd4),
            cfg_row(REG_EXTENT0, 5'd16),
            cfg_row(REG_EXTENT1, 5'd16),
            cfg_row(REG_EXTENT2, 5'd16),
            cfg_row(REG_EXTENT3, 5'd16),
            load_row(2'd3, 4'd15, 32'hFFFF_FFFF),
            query_row(32'd0),
            query_row(32'd65535),
            checked_row(32'd65536, 32'h0, 1'b1),
            cfg_row(REG_RIGHT_MAJOR, 5'd1),
            query_row(32'd65535),
            query_row(32'h0000_1234),
            checked_row(32'h8000_0000, 32'h0, 1'b1),
            cfg_row(REG_NUM_DIMS, 5'd0),
            cfg_row(REG_EXTENT0, 5'd0),
            query_row(32'd0),
            checked_row(32'd1, 32'h0, 1'b1),
            cfg_row(REG_NUM_DIMS, 5'd7),
            cfg_row(REG_EXTENT0, 5'd31),
            cfg_row(REG_EXTENT1, 5'd31),
            query_row(32'd65535),
            checked_row(32'd65536, 32'h0, 1'b1),
            cfg_row(REG_NUM_DIMS, 5'd2),
            cfg_row(REG_RIGHT_MAJOR, 5'd0),
            query_row(32'd255),
            load_row(2'd1, 4'd15, 32'h5A5A_5A5A),
            query_row(32'd243),
            cfg_row(REG_SPARE6, 5'd31),
            query_row(32'd200),
            cfg_row(REG_SPARE7, 5'd0),
            checked_row(32'd256, 32'h0, 1'b1),
            cfg_row(REG_NUM_DIMS, 5'd3),
            cfg_row(REG_EXTENT2, 5'd0),
            query_row(32'd255),
            checked_row(32'd256, 32'h0, 1'b1)
        };

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = directed_rows[i];
            case (row.kind)
                ROW_CFG:
                begin
                    write_reg(row.reg_index, row.reg_data);
                end
                ROW_LOAD:
                begin
                    send_item(OP_LOAD, row.dsel, row.pos, row.value, row.off, 1'b0, '0);
                end
                default:
                begin
                    send_item(OP_QUERY, row.dsel, row.pos, row.value, row.off, row.typed,
                              row.expected);
                end
            endcase
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    dims = 5'd4;
                    rmajor = 1'b0;
                    ext = '{5'd16, 5'd16, 5'd16, 5'd16};
                end
                1:
                begin
                    dims = 5'd4;
                    rmajor = 1'b1;
                    ext = '{5'd16, 5'd16, 5'd16, 5'd16};
                end
                2:
                begin
                    dims = 5'd1;
                    rmajor = 1'b0;
                    ext = '{5'd1, 5'd1, 5'd1, 5'd1};
                end
                3:
                begin
                    dims = 5'd7;
                    rmajor = 1'b1;
                    ext = '{5'd31, 5'd0, 5'd17, 5'd16};
                end
                default:
                begin
                    dims = CFG_DATA_W'($urandom_range(7));
                    rmajor = 1'($urandom_range(1));
                    for (int d = 0; d < NUM_EXT; d++)
                    begin
                        ext[d] = random_extent();
                    end
                end
            endcase
            apply_setting(dims, rmajor, ext[0], ext[1], ext[2], ext[3]);
            calm = (phase == CALM_PHASE);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                random_item();
            end
            calm = 1'b0;
        end

        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_tuples.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d table loads and %0d queries over %0d register writes.",
                 loads_sent, queries_sent, config_writes);
        $display("Checked %0d results, %0d of them out of range; %0d mismatches.",
                 tuples_checked, oor_checked, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/mroi_pkg.sv
rtl/mroi_in_if.sv
rtl/mroi_out_if.sv
rtl/mroi_ram.sv
rtl/mroi_div_step.sv
rtl/mroi_seq.sv
rtl/mixed_radix_offset_to_index.sv
bench/tb_mixed_radix_offset_to_index.sv
